// ===== sv/tcw_pkg.sv =====
// Shared constants and types for the text console writer.
package tcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLS * ROWS;

  localparam int ADDR_W  = 11;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int CELL_W  = CHAR_W + 2 * COLOR_W;
  localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam addr_t BOT_START = ADDR_W'(CELL_COUNT - COLS);
  localparam addr_t ADDR_COLS = ADDR_W'(COLS);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam cell_t             FILL_CELL    = 16'h200F;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

endpackage

// ===== sv/tcw_if.sv =====
// Valid/ready channel interfaces for console requests and results.
interface tcw_in_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [CHAR_W-1:0]  character;
  logic [COLOR_W-1:0] fore_color;
  logic [COLOR_W-1:0] back_color;
  logic [ADDR_W-1:0]  cell_address;

  modport source (output valid, func, character, fore_color, back_color, cell_address,
                  input ready);
  modport sink   (input valid, func, character, fore_color, back_color, cell_address,
                  output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  cell_char;
  logic [COLOR_W-1:0] cell_fore;
  logic [COLOR_W-1:0] cell_back;
  logic [ADDR_W-1:0]  cursor_position;
  logic               scrolled;
  logic               address_error;

  modport source (output valid, cell_char, cell_fore, cell_back, cursor_position, scrolled,
                  address_error, input ready);
  modport sink   (input valid, cell_char, cell_fore, cell_back, cursor_position, scrolled,
                  address_error, output ready);
endinterface

// ===== sv/text_console_writer.sv =====
// Text console writer: cell store, cursor, scroll engine and result register.
// A put without scroll gives its result in the cycle after its transfer; a read passes through
// ST_READ and then the result register. A put that scrolls sweeps the whole cell memory once.
// Throughput: one put per cycle while no scroll runs and out_if.ready takes each result; a read blocks
// new requests until its result is registered. Reset: synchronous active-low; afterwards a clearing
// pass writes zero to every cell, with in_if.ready low; the cursor starts at cell 0.
module text_console_writer import tcw_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  tcw_in_if.sink    in_if,
  tcw_out_if.source out_if
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  addr_t            idx_r, idx_nxt;
  addr_t            cur_r, cur_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pend_v_r, pend_v_nxt;
  addr_t            pend_addr_r, pend_addr_nxt;
  logic             pend_fill_r, pend_fill_nxt;
  logic             err_r, err_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [COLOR_W-1:0] out_fore_r, out_fore_nxt;
  logic [COLOR_W-1:0] out_back_r, out_back_nxt;
  addr_t              out_cur_r, out_cur_nxt;
  logic               out_scr_r, out_scr_nxt;
  logic               out_err_r, out_err_nxt;

  logic  ram_we;
  addr_t ram_waddr, ram_raddr;
  cell_t ram_wdata, ram_rdata;

  logic in_xfer, is_nl, end_col, end_row, need_scroll;

  tcw_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign is_nl       = (in_if.character == NEWLINE_BYTE);
  assign end_col     = (col_r == LAST_COL);
  assign end_row     = (row_r == LAST_ROW);
  assign need_scroll = end_row && (is_nl || end_col);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pend_v_nxt    = 1'b0;
    pend_addr_nxt = idx_r;
    pend_fill_nxt = (idx_r >= BOT_START);
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_char_nxt  = out_char_r;
    out_fore_nxt  = out_fore_r;
    out_back_nxt  = out_back_r;
    out_cur_nxt   = out_cur_r;
    out_scr_nxt   = out_scr_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = {in_if.character, in_if.fore_color, in_if.back_color};
    ram_raddr     = in_if.cell_address;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = '0;
        if (idx_r == LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_if.func == FUNC_READ) begin
            err_nxt   = (in_if.cell_address > LAST_CELL);
            state_nxt = ST_READ;
          end else begin
            ram_we = !is_nl;
            if (need_scroll) begin
              cur_nxt   = BOT_START;
              col_nxt   = '0;
              row_nxt   = LAST_ROW;
              idx_nxt   = '0;
              state_nxt = ST_SCROLL;
            end else begin
              if (is_nl || end_col) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
                cur_nxt = is_nl ? (cur_r + ADDR_COLS - ADDR_W'(col_r)) : (cur_r + 1'b1);
              end else begin
                col_nxt = col_r + 1'b1;
                cur_nxt = cur_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_char_nxt  = '0;
              out_fore_nxt  = '0;
              out_back_nxt  = '0;
              out_cur_nxt   = cur_nxt;
              out_scr_nxt   = 1'b0;
              out_err_nxt   = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = err_r ? '0 : ram_rdata[CELL_W-1 -: CHAR_W];
        out_fore_nxt  = err_r ? '0 : ram_rdata[2*COLOR_W-1 -: COLOR_W];
        out_back_nxt  = err_r ? '0 : ram_rdata[COLOR_W-1:0];
        out_cur_nxt   = cur_r;
        out_scr_nxt   = 1'b0;
        out_err_nxt   = err_r;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        ram_raddr  = idx_r + ADDR_COLS;
        pend_v_nxt = 1'b1;
        if (idx_r == LAST_CELL) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = '0;
        out_fore_nxt  = '0;
        out_back_nxt  = '0;
        out_cur_nxt   = cur_r;
        out_scr_nxt   = 1'b1;
        out_err_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase

    if (pend_v_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_fill_r ? FILL_CELL : ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      cur_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cur_r       <= cur_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_addr_r <= pend_addr_nxt;
    pend_fill_r <= pend_fill_nxt;
    err_r       <= err_nxt;
    out_char_r  <= out_char_nxt;
    out_fore_r  <= out_fore_nxt;
    out_back_r  <= out_back_nxt;
    out_cur_r   <= out_cur_nxt;
    out_scr_r   <= out_scr_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.cell_char       = out_char_r;
  assign out_if.cell_fore       = out_fore_r;
  assign out_if.cell_back       = out_back_r;
  assign out_if.cursor_position = out_cur_r;
  assign out_if.scrolled        = out_scr_r;
  assign out_if.address_error   = out_err_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r <= LAST_CELL) && (col_r <= LAST_COL) && (row_r <= LAST_ROW))
    else $error("cursor outside the screen");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!out_valid_r && !in_if.ready))
    else $error("activity during the clearing pass");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |-> (out_cur_r == BOT_START))
    else $error("scroll result with cursor off the bottom row start");

  a_drain_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (pend_v_r && $past(idx_r) == LAST_CELL))
    else $error("scroll sweep ended early");

endmodule

// ===== sv/tcw_cell_ram.sv =====
// Screen cell memory: one write port, one registered read port.
module tcw_cell_ram import tcw_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  cell_t wdata,
  input  addr_t raddr,
  output cell_t rdata
);

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
